@@ hdl/cns_pkg.sv @@
// shared constants, types and helpers for conditional neighbour smoothing
// no dependencies; used by cns_mean, cns_ram users and the top level
`timescale 1ns / 1ps

package cns_pkg;

  localparam int MAX_WIDTH  = 32;
  localparam int MAX_HEIGHT = 1024;
  localparam int ROWS       = 3;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SLOT_W     = 2;
  localparam int ADDR_W     = SLOT_W + COL_W;
  localparam int DEPTH      = ROWS * MAX_WIDTH;
  localparam int LEVEL_W    = 4;
  localparam int FW_W       = 6;
  localparam int FH_W       = 11;
  localparam int CFG_W      = 11;

  localparam logic [LEVEL_W-1:0] MAX_LEVEL = 4'd9;

  localparam logic [FW_W-1:0] FW_RESET = 6'd30;
  localparam logic [FH_W-1:0] FH_RESET = 11'd20;
  localparam logic [FW_W-1:0] FW_MAX   = 6'd32;
  localparam logic [FH_W-1:0] FH_MAX   = 11'd1024;

  // register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic has_up;
    logic has_down;
    logic has_left;
    logic has_right;
  } nbr_t;

  function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_prev(input logic [SLOT_W-1:0] s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

  function automatic logic [LEVEL_W-1:0] sat_level(input logic [LEVEL_W-1:0] v);
    return (v > MAX_LEVEL) ? MAX_LEVEL : v;
  endfunction

  function automatic logic [7:0] glyph_of(input logic [LEVEL_W-1:0] lv);
    logic [7:0] g;
    case (lv)
      4'd0:    g = 8'h20;
      4'd1:    g = 8'h2E;
      4'd2:    g = 8'h27;
      4'd3:    g = 8'h3A;
      4'd4:    g = 8'h7E;
      4'd5:    g = 8'h2A;
      4'd6:    g = 8'h3D;
      4'd7:    g = 8'h20;
      4'd8:    g = 8'h25;
      4'd9:    g = 8'h23;
      default: g = 8'h20;
    endcase
    return g;
  endfunction

endpackage

@@ hdl/cns_ram.sv @@
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module cns_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 96
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/cns_mean.sv @@
// neighbour check and rounded mean for one pixel
// depends on cns_pkg
`timescale 1ns / 1ps

module cns_mean (
  input  logic [cns_pkg::LEVEL_W-1:0] center,
  input  logic [cns_pkg::LEVEL_W-1:0] up,
  input  logic [cns_pkg::LEVEL_W-1:0] down,
  input  logic [cns_pkg::LEVEL_W-1:0] left,
  input  logic [cns_pkg::LEVEL_W-1:0] right,
  input  cns_pkg::nbr_t               nbr,
  output logic [cns_pkg::LEVEL_W-1:0] level,
  output logic                        smoothed
);

  logic [5:0]  sum;
  logic [2:0]  cnt;
  logic        ok;
  logic [12:0] prod3;
  logic [3:0]  mean;

  function automatic logic close(input logic [3:0] a, input logic [3:0] b);
    logic [3:0] d;
    d = (a > b) ? a - b : b - a;
    return d <= 4'd1;
  endfunction

  always_comb begin
    sum = 6'd0;
    cnt = 3'd0;
    ok  = 1'b1;
    if (nbr.has_up) begin
      sum = sum + 6'(up);
      cnt = cnt + 3'd1;
      ok  = ok & close(center, up);
    end
    if (nbr.has_down) begin
      sum = sum + 6'(down);
      cnt = cnt + 3'd1;
      ok  = ok & close(center, down);
    end
    if (nbr.has_left) begin
      sum = sum + 6'(left);
      cnt = cnt + 3'd1;
      ok  = ok & close(center, left);
    end
    if (nbr.has_right) begin
      sum = sum + 6'(right);
      cnt = cnt + 3'd1;
      ok  = ok & close(center, right);
    end
  end

  // (sum + 1) / 3 via reciprocal, exact for sums below 47
  assign prod3 = 13'({1'b0, sum} + 7'd1) * 13'd43;

  always_comb begin
    case (cnt)
      3'd1:    mean = sum[3:0];
      3'd2:    mean = 4'((7'({1'b0, sum}) + 7'd1) >> 1);
      3'd3:    mean = prod3[10:7];
      3'd4:    mean = 4'((7'({1'b0, sum}) + 7'd2) >> 2);
      default: mean = center;
    endcase
  end

  always_comb begin
    if (ok && cnt != 3'd0) begin
      level    = cns_pkg::sat_level(mean);
      smoothed = 1'b1;
    end else begin
      level    = center;
      smoothed = 1'b0;
    end
  end

endmodule

@@ hdl/conditional_neighbour_smoothing.sv @@
// top level of conditional neighbour smoothing with glyph output
// depends on cns_pkg, cns_ram and cns_mean
`timescale 1ns / 1ps

// usage
// input channel: pixel_level words in raster order, taken when in_valid is high
// and in_stall is low. output channel: glyph, out_level, was_smoothed and
// end_of_frame, taken when out_valid is high and out_stall is low.
// output lags one row: the word at row r releases pixel (r-1, c). the last
// word of a frame also releases the whole last row, end_of_frame marks its
// final pixel. three line buffers live in one 96 x 4 ram with one read port;
// each released pixel needs four reads (center, up, left, right); in_stall
// stays high after a releasing word until its last pixel is loaded into the
// output register, while a word that releases nothing leaves it low.
// a waiting result sits in the output register while the next word is taken;
// a stalled receiver holds it there and the block waits before the next one.
// config writes (cfg_write, cfg_index, cfg_data) are to go in while idle; the
// block does not enforce it. they restart the frame position. reset loads
// width 30 and height 20, empties the output register and keeps ram contents.
module conditional_neighbour_smoothing (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic                        cfg_index,
  input  logic [cns_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [cns_pkg::LEVEL_W-1:0] pixel_level,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  glyph,
  output logic [cns_pkg::LEVEL_W-1:0] out_level,
  output logic                        was_smoothed,
  output logic                        end_of_frame
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RC   = 6'b000010,
    S_RU   = 6'b000100,
    S_RL   = 6'b001000,
    S_RR   = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [cns_pkg::FW_W-1:0]   frame_width;
  logic [cns_pkg::FH_W-1:0]   frame_height;
  logic [cns_pkg::FW_W-1:0]   w_eff;
  logic [cns_pkg::FH_W-1:0]   h_eff;

  logic [cns_pkg::COL_W-1:0]  column_count;
  logic [cns_pkg::ROW_W-1:0]  row_count;
  logic [cns_pkg::SLOT_W-1:0] slot;

  logic [cns_pkg::COL_W-1:0]   e_col;
  logic [cns_pkg::SLOT_W-1:0]  e_cslot;
  logic [cns_pkg::SLOT_W-1:0]  e_uslot;
  logic                        e_hasup;
  logic                        e_hasdown;
  logic [cns_pkg::LEVEL_W-1:0] e_down;
  logic                        e_flush;
  logic                        flush_next;
  logic [cns_pkg::SLOT_W-1:0]  f_slot;
  logic                        f_hasup;

  logic [cns_pkg::LEVEL_W-1:0] center_q;
  logic [cns_pkg::LEVEL_W-1:0] up_q;
  logic [cns_pkg::LEVEL_W-1:0] left_q;
  logic [cns_pkg::LEVEL_W-1:0] rd_data;
  logic [cns_pkg::ADDR_W-1:0]  rd_addr;
  logic                        rd_en;

  logic                        in_accept;
  logic [cns_pkg::LEVEL_W-1:0] v_sat;
  logic                        last_col;
  logic                        last_row;
  logic                        e_last;
  logic                        out_load;
  cns_pkg::nbr_t               nbr;
  logic [cns_pkg::LEVEL_W-1:0] level;
  logic                        smoothed;

  // effective frame size
  always_comb begin
    if (frame_width == '0) begin
      w_eff = 6'd1;
    end else if (frame_width > cns_pkg::FW_MAX) begin
      w_eff = cns_pkg::FW_MAX;
    end else begin
      w_eff = frame_width;
    end
    if (frame_height == '0) begin
      h_eff = 11'd1;
    end else if (frame_height > cns_pkg::FH_MAX) begin
      h_eff = cns_pkg::FH_MAX;
    end else begin
      h_eff = frame_height;
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid & ~in_stall;
  assign v_sat     = cns_pkg::sat_level(pixel_level);
  assign last_col  = (6'({1'b0, column_count}) + 6'd1) == w_eff;
  assign last_row  = (11'({1'b0, row_count}) + 11'd1) == h_eff;
  assign e_last    = (6'({1'b0, e_col}) + 6'd1) == w_eff;

  assign nbr.has_up    = e_hasup;
  assign nbr.has_down  = e_hasdown;
  assign nbr.has_left  = (e_col != '0);
  assign nbr.has_right = (6'({1'b0, e_col}) + 6'd1) < w_eff;

  assign out_load = (state == S_EMIT) && (!out_valid || !out_stall);

  // read sequence: center, up, left, right
  always_comb begin
    rd_en = 1'b1;
    case (state)
      S_RC:    rd_addr = {e_cslot, e_col};
      S_RU:    rd_addr = {e_uslot, e_col};
      S_RL:    rd_addr = {e_cslot, e_col - 5'd1};
      S_RR:    rd_addr = {e_cslot, e_col + 5'd1};
      default: begin
        rd_addr = {e_cslot, e_col};
        rd_en   = 1'b0;
      end
    endcase
  end

  cns_ram #(
    .WIDTH (cns_pkg::LEVEL_W),
    .DEPTH (cns_pkg::DEPTH)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (in_accept),
    .wr_addr ({slot, column_count}),
    .wr_data (v_sat),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  cns_mean u_mean (
    .center   (center_q),
    .up       (up_q),
    .down     (e_down),
    .left     (left_q),
    .right    (rd_data),
    .nbr      (nbr),
    .level    (level),
    .smoothed (smoothed)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_accept && (row_count != '0 || (last_col && last_row))) begin
          state_next = S_RC;
        end
      end
      S_RC: state_next = S_RU;
      S_RU: state_next = S_RL;
      S_RL: state_next = S_RR;
      S_RR: state_next = S_EMIT;
      S_EMIT: begin
        if (out_load) begin
          if ((e_flush && !e_last) || (!e_flush && flush_next)) begin
            state_next = S_RC;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      frame_width  <= cns_pkg::FW_RESET;
      frame_height <= cns_pkg::FH_RESET;
      column_count <= '0;
      row_count    <= '0;
      slot         <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_accept && !cfg_write) begin
        if (last_col && last_row) begin
          column_count <= '0;
          row_count    <= '0;
          slot         <= '0;
        end else if (last_col) begin
          column_count <= '0;
          row_count    <= row_count + 10'd1;
          slot         <= cns_pkg::slot_next(slot);
        end else begin
          column_count <= column_count + 5'd1;
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          cns_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[cns_pkg::FW_W-1:0];
          cns_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
          default: ;
        endcase
        column_count <= '0;
        row_count    <= '0;
        slot         <= '0;
      end
    end
  end

  // pixel being released and read captures
  always_ff @(posedge clk) begin
    if (in_accept) begin
      f_slot  <= slot;
      f_hasup <= (row_count != '0);
      if (row_count != '0) begin
        e_flush    <= 1'b0;
        e_col      <= column_count;
        e_cslot    <= cns_pkg::slot_prev(slot);
        e_uslot    <= cns_pkg::slot_next(slot);
        e_hasup    <= (row_count > 10'd1);
        e_hasdown  <= 1'b1;
        e_down     <= v_sat;
        flush_next <= last_col && last_row;
      end else begin
        e_flush    <= 1'b1;
        e_col      <= '0;
        e_cslot    <= slot;
        e_uslot    <= cns_pkg::slot_prev(slot);
        e_hasup    <= 1'b0;
        e_hasdown  <= 1'b0;
        flush_next <= 1'b0;
      end
    end else if (out_load) begin
      if (e_flush) begin
        e_col <= e_col + 5'd1;
      end else begin
        e_flush    <= 1'b1;
        flush_next <= 1'b0;
        e_col      <= '0;
        e_cslot    <= f_slot;
        e_uslot    <= cns_pkg::slot_prev(f_slot);
        e_hasup    <= f_hasup;
        e_hasdown  <= 1'b0;
      end
    end
    if (state == S_RU) begin
      center_q <= rd_data;
    end
    if (state == S_RL) begin
      up_q <= rd_data;
    end
    if (state == S_RR) begin
      left_q <= rd_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      glyph        <= cns_pkg::glyph_of(level);
      out_level    <= level;
      was_smoothed <= smoothed;
      end_of_frame <= e_flush && e_last;
    end
  end

endmodule

@@ sim/cns_check.sv @@
// checker for conditional neighbour smoothing: watches config writes and both channels,
// predicts every output word from its own line buffers and compares in order
// depends on cns_pkg; reports failure and pending counts to the test top
`timescale 1ns / 1ps

module cns_check
  import cns_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [LEVEL_W-1:0] pixel_level,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [7:0]         glyph,
  input  logic [LEVEL_W-1:0] out_level,
  input  logic               was_smoothed,
  input  logic               end_of_frame,
  output int                 errors,
  output int                 pending,
  output int                 checked
);

  typedef struct packed {
    logic [7:0]         glyph;
    logic [LEVEL_W-1:0] level;
    logic               smoothed;
    logic               last;
  } pixel_out_t;

  // glyph per level, level 0 in the low byte
  localparam logic [79:0] GLYPH_ROW = {8'h23, 8'h25, 8'h20, 8'h3D, 8'h2A,
                                       8'h7E, 8'h3A, 8'h27, 8'h2E, 8'h20};

  logic [FW_W-1:0]    width_reg;
  logic [FH_W-1:0]    height_reg;
  logic [LEVEL_W-1:0] line_buf [ROWS][MAX_WIDTH];
  int                 col;
  int                 row;
  int                 fail_count;
  int                 seen_count;
  pixel_out_t         expected_q [$];

  initial begin
    for (int i = 0; i < ROWS; i++)
      for (int j = 0; j < MAX_WIDTH; j++)
        line_buf[i][j] = '0;
  end

  function automatic int cols_in_use();
    if (width_reg == 0) return 1;
    if (width_reg > FW_MAX) return FW_MAX;
    return width_reg;
  endfunction

  function automatic int rows_in_use();
    if (height_reg == 0) return 1;
    if (height_reg > FH_MAX) return FH_MAX;
    return height_reg;
  endfunction

  function automatic pixel_out_t smooth_pixel(int r, int c, int w, int h, logic last);
    int         nb [4];
    int         n;
    int         me;
    int         sum;
    int         q;
    int         rem;
    int         lvl;
    logic       ok;
    pixel_out_t p;
    n = 0;
    if (r > 0) begin
      nb[n] = line_buf[(r - 1) % 3][c];
      n++;
    end
    if (r + 1 < h) begin
      nb[n] = line_buf[(r + 1) % 3][c];
      n++;
    end
    if (c > 0) begin
      nb[n] = line_buf[r % 3][c - 1];
      n++;
    end
    if (c + 1 < w) begin
      nb[n] = line_buf[r % 3][c + 1];
      n++;
    end
    me  = line_buf[r % 3][c];
    sum = 0;
    ok  = 1'b1;
    for (int i = 0; i < n; i++) begin
      sum += nb[i];
      if (nb[i] > me + 1 || me > nb[i] + 1) ok = 1'b0;
    end
    lvl = me;
    if (ok && n > 0) begin
      // round to nearest, ties up
      q   = sum / n;
      rem = sum - n * q;
      lvl = (2 * rem < n) ? q : q + 1;
      if (lvl > MAX_LEVEL) lvl = MAX_LEVEL;
    end
    p.glyph    = GLYPH_ROW[lvl * 8 +: 8];
    p.level    = LEVEL_W'(lvl);
    p.smoothed = ok && n > 0;
    p.last     = last;
    return p;
  endfunction

  task automatic take_pixel(input logic [LEVEL_W-1:0] raw);
    int                 w;
    int                 h;
    logic [LEVEL_W-1:0] v;
    w = cols_in_use();
    h = rows_in_use();
    v = (raw > MAX_LEVEL) ? MAX_LEVEL : raw;
    line_buf[row % 3][col] = v;
    if (row > 0) expected_q.push_back(smooth_pixel(row - 1, col, w, h, 1'b0));
    if (col + 1 == w && row + 1 == h) begin
      // last word flushes the final row
      for (int j = 0; j < w; j++)
        expected_q.push_back(smooth_pixel(row, j, w, h, j + 1 == w));
      col = 0;
      row = 0;
    end else if (col + 1 == w) begin
      col = 0;
      row++;
    end else begin
      col++;
    end
  endtask

  task automatic note_mismatch(input string what, input pixel_out_t want,
                               input pixel_out_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%t mismatch (%s): expected glyph %h level %0d smoothed %0d eof %0d",
               $realtime, what, want.glyph, want.level, want.smoothed, want.last);
      $display("  got glyph %h level %0d smoothed %0d eof %0d",
               got.glyph, got.level, got.smoothed, got.last);
    end
  endtask

  always @(posedge clk) begin
    pixel_out_t got;
    pixel_out_t want;
    if (rst) begin
      width_reg  = FW_RESET;
      height_reg = FH_RESET;
      col        = 0;
      row        = 0;
      fail_count = 0;
      seen_count = 0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {glyph, out_level, was_smoothed, end_of_frame};
        seen_count++;
        if (expected_q.size() == 0) begin
          note_mismatch("no word expected", '0, got);
        end else begin
          want = expected_q.pop_front();
          if (got.glyph !== want.glyph || got.level !== want.level ||
              got.smoothed !== want.smoothed || got.last !== want.last)
            note_mismatch("field", want, got);
        end
      end
      if (cfg_write) begin
        if (cfg_index == REG_FRAME_WIDTH) width_reg = cfg_data[FW_W-1:0];
        else height_reg = cfg_data[FH_W-1:0];
        col = 0;
        row = 0;
      end
      if (in_valid && !in_stall) take_pixel(pixel_level);
    end
    errors  <= fail_count;
    pending <= expected_q.size();
    checked <= seen_count;
  end

endmodule

@@ sim/conditional_neighbour_smoothing_test.sv @@
// test top for conditional neighbour smoothing: drives config writes and pixel words,
// varies both sides' idling and gives the verdict
// depends on cns_pkg, the conditional_neighbour_smoothing rtl and cns_check
`timescale 1ns / 1ps

module conditional_neighbour_smoothing_test;
  import cns_pkg::*;

  localparam int RANDOM_WORDS = 260;
  localparam int HOLD_OFF     = 40;
  localparam int TAIL_CYCLES  = 200;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic               cfg_index = 1'b0;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [LEVEL_W-1:0] pixel_level = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         glyph;
  logic [LEVEL_W-1:0] out_level;
  logic               was_smoothed;
  logic               end_of_frame;

  int fail_count;
  int pending;
  int checked;
  int send_idle = 27;
  int recv_idle = 63;
  int words_sent = 0;
  int random_words = 0;
  int setups = 0;

  conditional_neighbour_smoothing DUT (.*);

  cns_check checker_i (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
    .pixel_level(pixel_level), .out_valid(out_valid), .out_stall(out_stall),
    .glyph(glyph), .out_level(out_level), .was_smoothed(was_smoothed),
    .end_of_frame(end_of_frame), .errors(fail_count), .pending(pending),
    .checked(checked)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_idle);
  end

  task automatic send_word(input logic [LEVEL_W-1:0] lv);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel_level <= lv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (words_sent >= 200) begin
      send_idle = 0;
      recv_idle = 0;
    end else if (words_sent >= 100) begin
      send_idle = 63;
      recv_idle = 27;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // a word that releases nothing may still be in flight
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_frame(input logic [FW_W-1:0] wraw, input logic [FH_W-1:0] hraw);
    logic [CFG_W-FW_W-1:0] junk;
    junk = (CFG_W - FW_W)'($urandom_range(2 ** (CFG_W - FW_W) - 1));
    write_reg(REG_FRAME_WIDTH, {junk, wraw});
    write_reg(REG_FRAME_HEIGHT, hraw);
    setups++;
  endtask

  function automatic logic [LEVEL_W-1:0] next_level(int style, int base);
    int v;
    if (style < 15 || (style < 40 && $urandom_range(7) == 0))
      return LEVEL_W'($urandom_range(15));
    v = base + $urandom_range(2) - 1;
    if (v < 0) v = 0;
    if (v >= MAX_LEVEL) return LEVEL_W'($urandom_range(15, MAX_LEVEL));
    return LEVEL_W'(v);
  endfunction

  initial begin
    int phase;
    int cols;
    int rows;
    int total;
    int style;
    int base;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset geometry, first row only
    send_word(4'd15);
    send_word(4'd0);
    // zero width and height act as one, single pixel frames
    set_frame(6'd0, 11'd0);
    send_word(4'd9);
    send_word(4'd12);
    set_frame(6'd1, 11'd1);
    send_word(4'd0);
    // single row
    set_frame(6'd3, 11'd1);
    send_word(4'd4);
    send_word(4'd5);
    send_word(4'd4);
    set_frame(6'd2, 11'd2);
    send_word(4'd3);
    send_word(4'd3);
    send_word(4'd4);
    send_word(4'd3);
    set_frame(6'd3, 11'd3);
    send_word(4'd5);
    send_word(4'd4);
    send_word(4'd5);
    send_word(4'd5);
    send_word(4'd5);
    send_word(4'd6);
    send_word(4'd6);
    send_word(4'd6);
    send_word(4'd6);

    phase = 0;
    while (random_words < RANDOM_WORDS) begin
      case (phase)
        0: begin
          set_frame(6'd63, 11'd1);
          cols = MAX_WIDTH;
          rows = 1;
        end
        1: begin
          set_frame(6'd32, 11'd2);
          cols = MAX_WIDTH;
          rows = 2;
        end
        2: begin
          set_frame(6'd2, 11'd2047);
          cols = 2;
          rows = MAX_HEIGHT;
        end
        3: begin
          set_frame(6'd1, 11'd5);
          cols = 1;
          rows = 5;
        end
        default: begin
          cols = ($urandom_range(5) == 0) ? $urandom_range(MAX_WIDTH, 1)
                                          : $urandom_range(8, 1);
          rows = $urandom_range(5, 1);
          set_frame(FW_W'(cols), FH_W'(rows));
        end
      endcase
      total = cols * rows;
      // tall frame and some others are cut off by the next config write
      if (phase == 2) total = 9;
      else if (phase > 3 && $urandom_range(9) == 0) total = $urandom_range(total, 1);
      if (total > RANDOM_WORDS - random_words) total = RANDOM_WORDS - random_words;
      style = $urandom_range(99);
      base  = $urandom_range(MAX_LEVEL);
      repeat (total) begin
        send_word(next_level(style, base));
        random_words++;
      end
      phase++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("sent %0d pixel words (%0d random) over %0d geometries, checked %0d output words",
             words_sent, random_words, setups, checked);
    $display("geometry ranged from single pixels to full 32-wide rows, incl. saturated settings");
    if (fail_count == 0)
      $display("conditional_neighbour_smoothing regression: pass");
    else
      $display("conditional_neighbour_smoothing regression: fail");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d output words still expected", pending);
    $display("conditional_neighbour_smoothing regression: fail");
    $finish;
  end

endmodule
